// ----- src/pol_pkg.sv -----
// Shared constants, codes and types for the positional ordered list.
package pol_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT_AT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_LOOP     = 8'b0000_0010,
        S_SH_RD    = 8'b0000_0100,
        S_SH_WR    = 8'b0000_1000,
        S_PUT      = 8'b0001_0000,
        S_RD_FRONT = 8'b0010_0000,
        S_RD_BACK  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    // One write port and one read port per cycle into the entry store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage

// ----- src/pol_store.sv -----
// Entry store: single-port write, single-port read with registered read data.
module pol_store
(
    input  logic                             clk,
    input  pol_pkg::store_req_t              req,
    output logic [pol_pkg::DATA_W-1:0]       rdata
);

    logic [pol_pkg::DATA_W-1:0] mem [pol_pkg::CAPACITY];
    logic [pol_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/positional_ordered_list_top.sv -----
// Top level of the positional ordered list engine.
// Keeps up to CAPACITY (32) signed values in position order in a one-write,
// one-read store. A command is taken only while the engine is idle. An insert
// at position p into a list of n entries moves n-p entries one at a time
// through the store, each move a read (S_SH_RD) and then a write (S_SH_WR),
// and a remove at p moves n-1-p entries the same way; a rejected command
// moves none. The front and back values are then read back from the store,
// one read per cycle. The result sits in an output register, so the next
// command can be taken while the previous result waits.
module positional_ordered_list_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pol_pkg::CMD_W-1:0]          cmd,
    input  logic signed [pol_pkg::DATA_W-1:0]  value,
    input  logic [pol_pkg::POS_W-1:0]          position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pol_pkg::STATUS_W-1:0]       status,
    output logic [pol_pkg::COUNT_W-1:0]        count,
    output logic signed [pol_pkg::DATA_W-1:0]  front_value,
    output logic signed [pol_pkg::DATA_W-1:0]  back_value
);

    pol_pkg::state_t state_reg, state_next;

    logic [pol_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [pol_pkg::COUNT_W-1:0]  idx_reg, idx_next;
    logic [pol_pkg::COUNT_W-1:0]  pos_reg, pos_next;
    logic                         ins_reg, ins_next;
    logic [pol_pkg::DATA_W-1:0]   value_reg, value_next;
    logic [pol_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [pol_pkg::DATA_W-1:0]   front_reg, front_next;

    logic                         out_valid_reg, out_valid_next;
    logic [pol_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [pol_pkg::COUNT_W-1:0]  ocount_reg, ocount_next;
    logic [pol_pkg::DATA_W-1:0]   ofront_reg, ofront_next;
    logic [pol_pkg::DATA_W-1:0]   oback_reg, oback_next;

    pol_pkg::store_req_t          req;
    logic [pol_pkg::DATA_W-1:0]   rdata;

    logic                         accept;
    logic [pol_pkg::COUNT_W-1:0]  dec_pos;
    logic                         dec_ins;
    logic [pol_pkg::STATUS_W-1:0] dec_st;
    logic [pol_pkg::COUNT_W-1:0]  idx_step;
    logic                         more_cur;
    logic                         more_step;
    logic                         full;

    pol_store u_store
    (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign in_ready = (state_reg == pol_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= pol_pkg::COUNT_W'(pol_pkg::CAPACITY));

    // Command decode at acceptance: effective position and status.
    always_comb
    begin
        dec_pos = '0;
        dec_ins = 1'b0;
        dec_st  = pol_pkg::ST_BAD;
        unique case (cmd)
            pol_pkg::CMD_ADD_FRONT:
            begin
                dec_pos = '0;
                dec_ins = 1'b1;
            end
            pol_pkg::CMD_ADD_BACK:
            begin
                dec_pos = count_reg;
                dec_ins = 1'b1;
            end
            pol_pkg::CMD_INSERT_AT:
            begin
                dec_pos = position;
                dec_ins = 1'b1;
            end
            pol_pkg::CMD_REM_FRONT:
            begin
                dec_pos = '0;
            end
            pol_pkg::CMD_REM_BACK:
            begin
                dec_pos = count_reg - 1'b1;   // wraps high on empty, caught below
            end
            pol_pkg::CMD_REM_AT:
            begin
                dec_pos = position;
            end
            default:
            begin
                dec_pos = '0;
            end
        endcase

        if (cmd == pol_pkg::CMD_ADD_FRONT || cmd == pol_pkg::CMD_ADD_BACK ||
            cmd == pol_pkg::CMD_INSERT_AT)
        begin
            if (dec_pos > count_reg)
                dec_st = pol_pkg::ST_BAD;
            else if (full)
                dec_st = pol_pkg::ST_FULL;
            else
                dec_st = pol_pkg::ST_DONE;
        end
        else if (cmd == pol_pkg::CMD_REM_FRONT || cmd == pol_pkg::CMD_REM_BACK ||
                 cmd == pol_pkg::CMD_REM_AT)
        begin
            dec_st = (dec_pos >= count_reg) ? pol_pkg::ST_BAD : pol_pkg::ST_DONE;
        end
    end

    // Insert walks idx down from count toward pos; remove walks up from pos.
    assign idx_step  = ins_reg ? (idx_reg - 1'b1) : (idx_reg + 1'b1);
    assign more_cur  = ins_reg ? (idx_reg > pos_reg) : ((idx_reg + 1'b1) < count_reg);
    assign more_step = ins_reg ? (idx_step > pos_reg) : ((idx_step + 1'b1) < count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        ins_next       = ins_reg;
        value_next     = value_reg;
        st_next        = st_reg;
        front_next     = front_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        ocount_next    = ocount_reg;
        ofront_next    = ofront_reg;
        oback_next     = oback_reg;

        req.we    = 1'b0;
        req.waddr = '0;
        req.wdata = value_reg;
        req.re    = 1'b0;
        req.raddr = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            pol_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pos_next   = dec_pos;
                    ins_next   = dec_ins;
                    value_next = value;
                    st_next    = dec_st;
                    idx_next   = dec_ins ? count_reg : dec_pos;
                    state_next = (dec_st == pol_pkg::ST_DONE) ? pol_pkg::S_LOOP
                                                              : pol_pkg::S_RD_FRONT;
                end
            end
            pol_pkg::S_LOOP:
            begin
                if (more_cur)
                    state_next = pol_pkg::S_SH_RD;
                else if (ins_reg)
                    state_next = pol_pkg::S_PUT;
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = pol_pkg::S_RD_FRONT;
                end
            end
            pol_pkg::S_SH_RD:
            begin
                req.re     = 1'b1;
                req.raddr  = idx_step[pol_pkg::ADDR_W-1:0];
                state_next = pol_pkg::S_SH_WR;
            end
            pol_pkg::S_SH_WR:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg[pol_pkg::ADDR_W-1:0];
                req.wdata = rdata;
                idx_next  = idx_step;
                if (more_step)
                    state_next = pol_pkg::S_SH_RD;
                else if (ins_reg)
                    state_next = pol_pkg::S_PUT;
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = pol_pkg::S_RD_FRONT;
                end
            end
            pol_pkg::S_PUT:
            begin
                req.we     = 1'b1;
                req.waddr  = pos_reg[pol_pkg::ADDR_W-1:0];
                req.wdata  = value_reg;
                count_next = count_reg + 1'b1;
                state_next = pol_pkg::S_RD_FRONT;
            end
            pol_pkg::S_RD_FRONT:
            begin
                req.re     = 1'b1;
                req.raddr  = '0;
                state_next = pol_pkg::S_RD_BACK;
            end
            pol_pkg::S_RD_BACK:
            begin
                req.re     = 1'b1;
                req.raddr  = pol_pkg::ADDR_W'(count_reg - 1'b1);
                front_next = rdata;
                state_next = pol_pkg::S_DONE;
            end
            pol_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    ocount_next    = count_reg;
                    if (count_reg == '0)
                    begin
                        ofront_next = '0;
                        oback_next  = '0;
                    end
                    else
                    begin
                        ofront_next = front_reg;
                        oback_next  = rdata;
                    end
                    state_next = pol_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pol_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pol_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        ins_reg    <= ins_next;
        value_reg  <= value_next;
        st_reg     <= st_next;
        front_reg  <= front_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
        ofront_reg <= ofront_next;
        oback_reg  <= oback_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign count       = ocount_reg;
    assign front_value = ofront_reg;
    assign back_value  = oback_reg;

endmodule
